/* design/ctpl_pkg.sv */
// shared types, widths and step functions for the circle pair tangent line core
`timescale 1ns / 1ps
`default_nettype none
package ctpl_pkg;

    // field and datapath widths
    localparam int COORD_W     = 32;
    localparam int RAD_W       = 31;
    localparam int DIFF_W      = 34;   // signed center difference
    localparam int MAG_W       = 33;   // magnitude of a center difference
    localparam int SUM_W       = 32;   // magnitude of the radius sum or difference
    localparam int SQR_W       = 66;   // square of a difference magnitude
    localparam int S2_W        = 64;
    localparam int D2_W        = 67;
    localparam int EXTRA_BITS  = 31;   // fraction bits of the root below the coordinate lsb
    localparam int RADIC_W     = 128;
    localparam int ROOT_W      = 64;
    localparam int SQ_REM_W    = 66;
    localparam int SQ_STAGES   = ROOT_W;
    localparam int PROD_W      = 65;   // 33 by 32 partial product
    localparam int T1_W        = 96;
    localparam int T2_W        = 97;
    localparam int NMAG_W      = 98;
    localparam int CHUNK_W     = 32;
    localparam int CHUNKS      = 4;
    localparam int PP_W        = 63;   // chunk times radius
    localparam int NUM_W       = 128;
    localparam int DEN_W       = 98;
    localparam int QUO_W       = 64;
    localparam int DIV_STAGES  = NUM_W;
    localparam int COMB_STAGES = 6;
    localparam int FRONT_STAGES = 4;
    localparam int LANES       = 8;
    localparam int NORMALS     = 4;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_COINCIDENT = 2'd1,
        ST_NO_TANGENT = 2'd2
    } status_t;

    typedef enum logic {
        OP_EXTERNAL = 1'b0,
        OP_INTERNAL = 1'b1
    } opcode_t;

    typedef struct packed {
        logic               opcode;
        logic [COORD_W-1:0] center_a_x;
        logic [COORD_W-1:0] center_a_y;
        logic [RAD_W-1:0]   radius_a;
        logic [COORD_W-1:0] center_b_x;
        logic [COORD_W-1:0] center_b_y;
        logic [RAD_W-1:0]   radius_b;
    } in_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic [COORD_W-1:0] first_start_x;
        logic [COORD_W-1:0] first_start_y;
        logic [COORD_W-1:0] first_end_x;
        logic [COORD_W-1:0] first_end_y;
        logic [COORD_W-1:0] second_start_x;
        logic [COORD_W-1:0] second_start_y;
        logic [COORD_W-1:0] second_end_x;
        logic [COORD_W-1:0] second_end_y;
    } out_item_t;

    // fields needed only at the final placement
    typedef struct packed {
        status_t            status;
        logic [COORD_W-1:0] ax;
        logic [COORD_W-1:0] ay;
        logic [COORD_W-1:0] bx;
        logic [COORD_W-1:0] by;
    } side_t;

    // fields needed by the normal and numerator stages
    typedef struct packed {
        logic               internal;
        logic [MAG_W-1:0]   adx;
        logic [MAG_W-1:0]   ady;
        logic               dxn;
        logic               dyn;
        logic [SUM_W-1:0]   as_mag;
        logic               sn;
        logic [D2_W-1:0]    d2;
        logic [RAD_W-1:0]   ra;
        logic [RAD_W-1:0]   rb;
    } cin_t;

    typedef struct packed {
        side_t                side;
        cin_t                 cin;
        logic [RADIC_W-1:0]   radicand;
    } front_t;

    typedef struct packed {
        logic [NMAG_W-1:0] mag;
        logic              neg;
    } nmag_t;

    typedef struct packed {
        logic [LANES-1:0][NUM_W-1:0] num;
        logic [LANES-1:0]            neg;
        logic [DEN_W-1:0]            den;
    } comb_out_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
        logic [RADIC_W-1:0]  rad;
    } sq_stage_t;

    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [NUM_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic [DEN_W-1:0] den;
        logic             neg;
    } div_stage_t;

    // one result bit of the restoring square root
    function automatic sq_stage_t sq_step(input sq_stage_t a);
        sq_stage_t             r;
        logic [SQ_REM_W+1:0]   t;
        logic [SQ_REM_W+1:0]   trial;
        r = a;
        t = {a.rem, a.rad[RADIC_W-1 -: 2]};
        trial = {{(SQ_REM_W-ROOT_W){1'b0}}, a.root, 2'b01};
        if (t >= trial)
        begin
            r.rem  = SQ_REM_W'(t - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            r.rem  = SQ_REM_W'(t);
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        r.rad = {a.rad[RADIC_W-3:0], 2'b00};
        return r;
    endfunction

    // one quotient bit of the restoring divider
    function automatic div_stage_t div_step(input div_stage_t a);
        div_stage_t       r;
        logic [DEN_W:0]   t;
        logic             q;
        r = a;
        t = {a.rem, a.num[NUM_W-1]};
        q = (t >= {1'b0, a.den});
        if (q)
        begin
            r.rem = DEN_W'(t - {1'b0, a.den});
        end
        else
        begin
            r.rem = DEN_W'(t);
        end
        r.num = {a.num[NUM_W-2:0], 1'b0};
        r.quo = {a.quo[QUO_W-2:0], q};
        return r;
    endfunction

    // signed sum a*s*2^E +- b*H in sign and magnitude
    function automatic nmag_t combine(input logic [T1_W-1:0] t1, input logic aneg,
                                      input logic [T2_W-1:0] t2, input logic bneg,
                                      input logic flip, input logic sn);
        nmag_t              r;
        logic               n1;
        logic               n2;
        logic [NMAG_W-1:0]  a1;
        logic [NMAG_W-1:0]  a2;
        n1 = aneg ^ sn;
        n2 = bneg ^ flip;
        a1 = {{(NMAG_W-T1_W){1'b0}}, t1};
        a2 = {{(NMAG_W-T2_W){1'b0}}, t2};
        if (n1 == n2)
        begin
            r.mag = a1 + a2;
            r.neg = n1;
        end
        else if (a1 >= a2)
        begin
            r.mag = a1 - a2;
            r.neg = n1;
        end
        else
        begin
            r.mag = a2 - a1;
            r.neg = n2;
        end
        return r;
    endfunction

    // center plus or minus offset, saturated to the coordinate range
    function automatic logic [COORD_W-1:0] place(input logic [COORD_W-1:0] base,
                                                 input logic [QUO_W-1:0] q,
                                                 input logic neg);
        logic [QUO_W-1:0] b64;
        logic [QUO_W-1:0] v;
        logic [COORD_W-1:0] r;
        b64 = {{(QUO_W-COORD_W){base[COORD_W-1]}}, base};
        v = neg ? (b64 - q) : (b64 + q);
        if (!v[QUO_W-1] && (v[QUO_W-2:COORD_W-1] != '0))
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        else if (v[QUO_W-1] && (v[QUO_W-2:COORD_W-1] != '1))
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* design/ctpl_front.sv */
// front stages: differences, magnitudes, squares, distance and radicand
`timescale 1ns / 1ps
`default_nettype none
module ctpl_front
    import ctpl_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     en,
    input  wire logic     in_valid,
    input  wire in_item_t in_item,
    output logic          out_valid,
    output front_t        out_data
);

    logic                 v1_reg, v2_reg, v3_reg, v4_reg;
    in_item_t             i1_reg, i2_reg, i3_reg, i4_reg;
    logic [DIFF_W-1:0]    dx1_reg, dy1_reg;
    logic [SUM_W:0]       s1_reg;
    logic [DIFF_W-1:0]    dx_next, dy_next;
    logic [SUM_W:0]       s_next;
    logic [MAG_W-1:0]     adx2_reg, ady2_reg, adx3_reg, ady3_reg, adx4_reg, ady4_reg;
    logic [SUM_W-1:0]     as2_reg, as3_reg, as4_reg;
    logic                 dxn2_reg, dyn2_reg, sn2_reg, dxn3_reg, dyn3_reg, sn3_reg;
    logic                 dxn4_reg, dyn4_reg, sn4_reg;
    logic [SQR_W-1:0]     pxx3_reg, pyy3_reg;
    logic [S2_W-1:0]      ss3_reg;
    logic [D2_W-1:0]      d2_next, diff_next, d2_4_reg;
    logic [RADIC_W-1:0]   radic4_reg;
    status_t              st_next, st4_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // stage 1: center differences and radius sum or difference
    assign dx_next = {{2{in_item.center_b_x[COORD_W-1]}}, in_item.center_b_x}
                   - {{2{in_item.center_a_x[COORD_W-1]}}, in_item.center_a_x};
    assign dy_next = {{2{in_item.center_b_y[COORD_W-1]}}, in_item.center_b_y}
                   - {{2{in_item.center_a_y[COORD_W-1]}}, in_item.center_a_y};
    assign s_next  = (in_item.opcode == OP_INTERNAL)
                   ? ({2'b00, in_item.radius_a} + {2'b00, in_item.radius_b})
                   : ({2'b00, in_item.radius_a} - {2'b00, in_item.radius_b});

    // stage 4 combinational: distance squared, status and radicand
    assign d2_next   = {1'b0, pxx3_reg} + {1'b0, pyy3_reg};
    assign diff_next = d2_next - {{(D2_W-S2_W){1'b0}}, ss3_reg};

    always_comb
    begin
        if (d2_next == '0)
        begin
            st_next = ST_COINCIDENT;
        end
        else if ({{(D2_W-S2_W){1'b0}}, ss3_reg} > d2_next)
        begin
            st_next = ST_NO_TANGENT;
        end
        else
        begin
            st_next = ST_OK;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i1_reg  <= in_item;
            dx1_reg <= dx_next;
            dy1_reg <= dy_next;
            s1_reg  <= s_next;

            i2_reg   <= i1_reg;
            adx2_reg <= dx1_reg[DIFF_W-1] ? MAG_W'(-dx1_reg) : dx1_reg[MAG_W-1:0];
            ady2_reg <= dy1_reg[DIFF_W-1] ? MAG_W'(-dy1_reg) : dy1_reg[MAG_W-1:0];
            as2_reg  <= s1_reg[SUM_W] ? SUM_W'(-s1_reg) : s1_reg[SUM_W-1:0];
            dxn2_reg <= dx1_reg[DIFF_W-1];
            dyn2_reg <= dy1_reg[DIFF_W-1];
            sn2_reg  <= s1_reg[SUM_W];

            i3_reg   <= i2_reg;
            adx3_reg <= adx2_reg;
            ady3_reg <= ady2_reg;
            as3_reg  <= as2_reg;
            dxn3_reg <= dxn2_reg;
            dyn3_reg <= dyn2_reg;
            sn3_reg  <= sn2_reg;
            pxx3_reg <= adx2_reg * adx2_reg;
            pyy3_reg <= ady2_reg * ady2_reg;
            ss3_reg  <= as2_reg * as2_reg;

            i4_reg     <= i3_reg;
            adx4_reg   <= adx3_reg;
            ady4_reg   <= ady3_reg;
            as4_reg    <= as3_reg;
            dxn4_reg   <= dxn3_reg;
            dyn4_reg   <= dyn3_reg;
            sn4_reg    <= sn3_reg;
            d2_4_reg   <= d2_next;
            st4_reg    <= st_next;
            radic4_reg <= {diff_next[RADIC_W-2*EXTRA_BITS-1:0], {(2*EXTRA_BITS){1'b0}}};
        end
    end

    assign out_valid = v4_reg;

    always_comb
    begin
        out_data.side.status  = st4_reg;
        out_data.side.ax      = i4_reg.center_a_x;
        out_data.side.ay      = i4_reg.center_a_y;
        out_data.side.bx      = i4_reg.center_b_x;
        out_data.side.by      = i4_reg.center_b_y;
        out_data.cin.internal = i4_reg.opcode;
        out_data.cin.adx      = adx4_reg;
        out_data.cin.ady      = ady4_reg;
        out_data.cin.dxn      = dxn4_reg;
        out_data.cin.dyn      = dyn4_reg;
        out_data.cin.as_mag   = as4_reg;
        out_data.cin.sn       = sn4_reg;
        out_data.cin.d2       = d2_4_reg;
        out_data.cin.ra       = i4_reg.radius_a;
        out_data.cin.rb       = i4_reg.radius_b;
        out_data.radicand     = radic4_reg;
    end

endmodule
`default_nettype wire

/* design/ctpl_sqrt.sv */
// pipelined restoring square root, one root bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ctpl_sqrt
    import ctpl_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                en,
    input  wire logic [RADIC_W-1:0]  radicand,
    output logic [ROOT_W-1:0]        root
);

    sq_stage_t stage_reg [SQ_STAGES];
    sq_stage_t first;

    assign first = '{rem: '0, root: '0, rad: radicand};

    // each stage settles one root bit
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= sq_step(first);
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                stage_reg[k] <= sq_step(stage_reg[k-1]);
            end
        end
    end

    assign root = stage_reg[SQ_STAGES-1].root;

endmodule
`default_nettype wire

/* design/ctpl_comb.sv */
// normal vectors and rounded division numerators for the eight coordinates
`timescale 1ns / 1ps
`default_nettype none
module ctpl_comb
    import ctpl_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               en,
    input  wire cin_t               cin,
    input  wire logic [ROOT_W-1:0]  root,
    output comb_out_t               out_data
);

    localparam int HALF_W = ROOT_W / 2;

    cin_t                           c1_reg, c2_reg, c3_reg, c4_reg, c5_reg;
    logic [PROD_W-1:0]              pas1_reg, pbs1_reg, pxh1_reg, pxl1_reg, pyh1_reg, pyl1_reg;
    logic [T1_W-1:0]                t1x2_reg, t1y2_reg;
    logic [T2_W-1:0]                t2x2_reg, t2y2_reg;
    nmag_t [NORMALS-1:0]            n3_reg;
    logic [LANES-1:0][CHUNKS-1:0][PP_W-1:0] pp4_reg;
    logic [LANES-1:0]               neg4_reg, neg5_reg, neg6_reg;
    logic [LANES-1:0][NUM_W-1:0]    prod5_reg, num6_reg;
    logic [DEN_W-1:0]               den6_reg;
    logic [LANES-1:0][CHUNKS-1:0][PP_W-1:0] pp_next;
    logic [LANES-1:0]               neg_next;
    logic [LANES-1:0][NUM_W-1:0]    prod_next;
    logic [NUM_W-1:0]               half_den;

    // partial products for the lanes: normal times radius
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            logic [NUM_W-1:0] wide;
            logic [RAD_W-1:0] rad;
            logic             is_end;
            wide   = {{(NUM_W-NMAG_W){1'b0}}, n3_reg[(l/4)*2 + (l%2)].mag};
            is_end = ((l/2) % 2) == 1;
            rad    = is_end ? c3_reg.rb : c3_reg.ra;
            neg_next[l] = n3_reg[(l/4)*2 + (l%2)].neg ^ (is_end & c3_reg.internal);
            for (int j = 0; j < CHUNKS; j++)
            begin
                pp_next[l][j] = wide[j*CHUNK_W +: CHUNK_W] * rad;
            end
        end
    end

    // sum of partial products modulo 2^128
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            prod_next[l] = '0;
            for (int j = 0; j < CHUNKS; j++)
            begin
                prod_next[l] = prod_next[l]
                             + ({{(NUM_W-PP_W){1'b0}}, pp4_reg[l][j]} << (j*CHUNK_W));
            end
        end
    end

    assign half_den = {{(NUM_W-D2_W-EXTRA_BITS+1){1'b0}}, c5_reg.d2, {(EXTRA_BITS-1){1'b0}}};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // products with the radius term and with the root halves
            c1_reg   <= cin;
            pas1_reg <= cin.adx * cin.as_mag;
            pbs1_reg <= cin.ady * cin.as_mag;
            pxh1_reg <= cin.adx * root[ROOT_W-1:HALF_W];
            pxl1_reg <= cin.adx * root[HALF_W-1:0];
            pyh1_reg <= cin.ady * root[ROOT_W-1:HALF_W];
            pyl1_reg <= cin.ady * root[HALF_W-1:0];

            // aligned terms
            c2_reg   <= c1_reg;
            t1x2_reg <= {pas1_reg, {EXTRA_BITS{1'b0}}};
            t1y2_reg <= {pbs1_reg, {EXTRA_BITS{1'b0}}};
            t2x2_reg <= {pxh1_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pxl1_reg};
            t2y2_reg <= {pyh1_reg, {HALF_W{1'b0}}} + {{HALF_W{1'b0}}, pyl1_reg};

            // the four normal numerators
            c3_reg    <= c2_reg;
            n3_reg[0] <= combine(t1x2_reg, c2_reg.dxn, t2y2_reg, c2_reg.dyn, 1'b1, c2_reg.sn);
            n3_reg[1] <= combine(t1y2_reg, c2_reg.dyn, t2x2_reg, c2_reg.dxn, 1'b0, c2_reg.sn);
            n3_reg[2] <= combine(t1x2_reg, c2_reg.dxn, t2y2_reg, c2_reg.dyn, 1'b0, c2_reg.sn);
            n3_reg[3] <= combine(t1y2_reg, c2_reg.dyn, t2x2_reg, c2_reg.dxn, 1'b1, c2_reg.sn);

            c4_reg   <= c3_reg;
            pp4_reg  <= pp_next;
            neg4_reg <= neg_next;

            c5_reg    <= c4_reg;
            prod5_reg <= prod_next;
            neg5_reg  <= neg4_reg;

            // rounding bias of half the divisor
            for (int l = 0; l < LANES; l++)
            begin
                num6_reg[l] <= prod5_reg[l] + half_den;
            end
            neg6_reg <= neg5_reg;
            den6_reg <= {c5_reg.d2, {EXTRA_BITS{1'b0}}};
        end
    end

    assign out_data.num = num6_reg;
    assign out_data.neg = neg6_reg;
    assign out_data.den = den6_reg;

endmodule
`default_nettype wire

/* design/ctpl_div_lane.sv */
// pipelined restoring divider lane, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module ctpl_div_lane
    import ctpl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              en,
    input  wire logic [NUM_W-1:0]  num,
    input  wire logic [DEN_W-1:0]  den,
    input  wire logic              neg_in,
    output logic [QUO_W-1:0]       quo,
    output logic                   neg_out
);

    div_stage_t stage_reg [DIV_STAGES];
    div_stage_t first;

    assign first = '{rem: '0, num: num, quo: '0, den: den, neg: neg_in};

    // numerator bits enter from the top, one per stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= div_step(first);
            for (int k = 1; k < DIV_STAGES; k++)
            begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    assign quo     = stage_reg[DIV_STAGES-1].quo;
    assign neg_out = stage_reg[DIV_STAGES-1].neg;

endmodule
`default_nettype wire

/* design/circle_pair_tangent_lines_core.sv */
// top level of the circle pair common tangent line core
//
// Input channel in_valid/in_ready/in_item carries one circle pair and an opcode
// (external or internal tangents); output channel out_valid/out_ready/out_item
// carries the status and the touch points of both tangent lines.
// One beat enters per cycle and one beat leaves per cycle while the receiver does not stall.
// The pipeline has 4 front stages (differences, squares, distance),
// 64 square root stages (one root bit each), 6 stages for normals and
// numerators, 128 divider stages (one quotient bit each), one output register.
// The whole pipeline advances as one: it moves whenever the output register is
// empty or its beat is being taken, so in_ready is high in that case too.
// When the receiver stalls with a beat waiting, every stage holds its contents
// and in_ready drops; nothing is lost or repeated.
// Reset clears all valid bits; the output channel shows no beat until the
// first pair has gone through the pipeline.
// Coincident centers and pairs without such tangents give status codes with all
// coordinates zero.
`timescale 1ns / 1ps
`default_nettype none
module circle_pair_tangent_lines_core
    import ctpl_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    localparam int SIDE_LEN = SQ_STAGES + COMB_STAGES + DIV_STAGES;

    logic                       pipe_en;
    logic                       front_valid;
    front_t                     front_data;
    logic [ROOT_W-1:0]          root;
    cin_t                       cd_reg [SQ_STAGES];
    side_t                      sd_reg [SIDE_LEN];
    logic [SIDE_LEN-1:0]        vld_reg;
    comb_out_t                  comb_data;
    logic [LANES-1:0][QUO_W-1:0] lane_quo;
    logic [LANES-1:0]           lane_neg;
    side_t                      last_side;
    out_item_t                  out_next;
    logic                       out_valid_reg;
    out_item_t                  out_item_reg;

    // global advance: output register free or being drained
    assign pipe_en  = !out_valid_reg || out_ready;
    assign in_ready = pipe_en;

    ctpl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    ctpl_sqrt u_sqrt (
        .clk      (clk),
        .en       (pipe_en),
        .radicand (front_data.radicand),
        .root     (root)
    );

    // operands for the normal stages wait out the square root
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            cd_reg[0] <= front_data.cin;
            for (int k = 1; k < SQ_STAGES; k++)
            begin
                cd_reg[k] <= cd_reg[k-1];
            end
        end
    end

    ctpl_comb u_comb (
        .clk      (clk),
        .en       (pipe_en),
        .cin      (cd_reg[SQ_STAGES-1]),
        .root     (root),
        .out_data (comb_data)
    );

    // eight divider lanes, one per output coordinate
    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        ctpl_div_lane u_div (
            .clk     (clk),
            .en      (pipe_en),
            .num     (comb_data.num[l]),
            .den     (comb_data.den),
            .neg_in  (comb_data.neg[l]),
            .quo     (lane_quo[l]),
            .neg_out (lane_neg[l])
        );
    end

    // valid bits follow the data through the long stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= {vld_reg[SIDE_LEN-2:0], front_valid};
        end
    end

    // status and centers for the final placement
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sd_reg[0] <= front_data.side;
            for (int k = 1; k < SIDE_LEN; k++)
            begin
                sd_reg[k] <= sd_reg[k-1];
            end
        end
    end

    assign last_side = sd_reg[SIDE_LEN-1];

    // touch points, zeroed on a special case
    always_comb
    begin
        out_next = '0;
        out_next.status = last_side.status;
        if (last_side.status == ST_OK)
        begin
            out_next.first_start_x  = place(last_side.ax, lane_quo[0], lane_neg[0]);
            out_next.first_start_y  = place(last_side.ay, lane_quo[1], lane_neg[1]);
            out_next.first_end_x    = place(last_side.bx, lane_quo[2], lane_neg[2]);
            out_next.first_end_y    = place(last_side.by, lane_quo[3], lane_neg[3]);
            out_next.second_start_x = place(last_side.ax, lane_quo[4], lane_neg[4]);
            out_next.second_start_y = place(last_side.ay, lane_quo[5], lane_neg[5]);
            out_next.second_end_x   = place(last_side.bx, lane_quo[6], lane_neg[6]);
            out_next.second_end_y   = place(last_side.by, lane_quo[7], lane_neg[7]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= vld_reg[SIDE_LEN-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            out_item_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule
`default_nettype wire
